[sv/stra_pkg.sv]
// ----------------------------------------------------------------------------
// stra_pkg
// Shared types and constants for the segment tree with range add and point
// query: item layouts, operation and status codes, the engine command and
// its status group.
// ----------------------------------------------------------------------------
package stra_pkg;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_BAD_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                    mode;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         range_low;
    logic [POS_W-1:0]         range_high;
    logic signed [DATA_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    status_e                  status;
  } out_item_t;

  typedef struct packed {
    in_item_t         item;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic init;
    logic res_valid;
  } eng_stat_t;

endpackage

[sv/segment_tree_range_add_point_query.sv]
// ----------------------------------------------------------------------------
// segment_tree_range_add_point_query
// Heap-indexed segment tree over up to MAX_ELEMENTS 32-bit elements with
// element load, range add, point query and clear; one result item per item.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i| out_item_o (out_item_t)
//   cfg     | input     | cfg_we_i               | cfg_wdata_i (element count)
//
// One item at a time; the store has one read and one write port per cycle.
// Clear sweeps all 4*MAX_ELEMENTS store entries; the same sweep runs after reset
// with in_stall_o high. A finished result waits in the output register while the
// next item is taken.
// ----------------------------------------------------------------------------
module segment_tree_range_add_point_query import stra_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  logic [CNT_W-1:0] element_count_q;
  logic [CNT_W-1:0] act_count;
  cmd_t             cmd;
  out_item_t        res;
  eng_stat_t        eng_stat;
  logic             start, res_take;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      element_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (element_count_q == '0) begin
      act_count = CNT_W'(1);
    end else if (32'(element_count_q) > 32'(MAX_ELEMENTS)) begin
      act_count = CNT_W'(MAX_ELEMENTS);
    end else begin
      act_count = element_count_q;
    end
  end

  assign cmd.item  = in_item_i;
  assign cmd.count = act_count;
  assign start     = in_valid_i && eng_stat.ready;
  assign res_take  = eng_stat.res_valid && (!out_valid_q || !out_stall_i);

  stra_engine #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_i     (cmd),
    .res_take_i(res_take),
    .res_o     (res),
    .stat_o    (eng_stat)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res;
    end
  end

  assign in_stall_o  = !eng_stat.ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_init_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.init |-> in_stall_o)
    else $error("item accepted during store sweep");

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.res_valid |-> !eng_stat.ready)
    else $error("result pending while engine idle");

  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_o)
    else $error("taken result not shown");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != ST_DONE)) |-> (out_item_o.read_value == '0))
    else $error("rejected item with nonzero value");

endmodule

[sv/stra_engine.sv]
// ----------------------------------------------------------------------------
// stra_engine
// Tree store and its sequencer. Loads and queries walk root to leaf and push
// pending adds down; range adds run a depth-first walk with a small stack of
// right siblings; clears sweep the store one entry a cycle.
// ----------------------------------------------------------------------------
module stra_engine import stra_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  cmd_t      cmd_i,
  input  logic      res_take_i,
  output out_item_t res_o,
  output eng_stat_t stat_o
);

  localparam int unsigned DEPTH = 4 * MAX_ELEMENTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SD    = $clog2(MAX_ELEMENTS) + 1;
  localparam int unsigned SIW   = $clog2(SD);
  localparam int unsigned SPW   = $clog2(SD + 1);

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CLEAR = 10'b0000000100,
    S_D_RD  = 10'b0000001000,
    S_D_CHK = 10'b0000010000,
    S_D_PL  = 10'b0000100000,
    S_D_PR  = 10'b0001000000,
    S_D_PZ  = 10'b0010000000,
    S_VISIT = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] e;
    logic [AW-1:0]    node;
  } stk_ent_t;

  state_e           state_q, state_d;
  logic             add_q, add_d;
  in_item_t         item_q, item_d;
  logic [AW-1:0]    node_q, node_d;
  logic [CNT_W-1:0] s_q, s_d, e_q, e_d;
  logic [DATA_W-1:0] p_q, p_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [SPW-1:0]   sp_q, sp_d;
  stk_ent_t         stk_q [SD];
  logic             push;
  stk_ent_t         push_ent, top_ent;
  out_item_t        res_q, res_d;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd;

  logic [CNT_W-1:0] mid, lo_x, hi_x, pos_x;
  logic [AW-1:0]    lchild, rchild;
  logic             go_left, disjoint, covered;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_q[sp_q[SIW-1:0]] <= push_ent;
    end
  end

  assign mid     = s_q + ((e_q - s_q) >> 1);
  assign lchild  = (node_q << 1) + AW'(1);
  assign rchild  = (node_q << 1) + AW'(2);
  assign pos_x   = CNT_W'(item_q.position);
  assign lo_x    = CNT_W'(item_q.range_low);
  assign hi_x    = CNT_W'(item_q.range_high);
  assign go_left = pos_x <= mid;
  assign disjoint = (e_q < lo_x) || (s_q > hi_x);
  assign covered  = (s_q == e_q) || ((s_q >= lo_x) && (e_q <= hi_x));
  assign top_ent  = stk_q[SIW'(sp_q - SPW'(1))];
  assign push_ent = '{s: mid + CNT_W'(1), e: e_q, node: rchild};

  always_comb begin
    state_d = state_q;
    add_d   = add_q;
    item_d  = item_q;
    node_d  = node_q;
    s_d     = s_q;
    e_d     = e_q;
    p_d     = p_q;
    clr_d   = clr_q;
    sp_d    = sp_q;
    res_d   = res_q;
    push    = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = node_q;
    mem_wd  = '0;
    mem_ra  = node_q;

    unique case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          item_d = cmd_i.item;
          node_d = '0;
          s_d    = '0;
          e_d    = cmd_i.count - CNT_W'(1);
          sp_d   = '0;
          clr_d  = '0;
          add_d  = 1'b0;
          res_d  = '{read_value: '0, status: ST_DONE};
          unique case (cmd_i.item.mode)
            MODE_LOAD, MODE_QUERY: begin
              if (CNT_W'(cmd_i.item.position) >= cmd_i.count) begin
                res_d.status = ST_BAD_POS;
                state_d      = S_DONE;
              end else begin
                state_d = S_D_RD;
              end
            end
            MODE_ADD: begin
              if ((cmd_i.item.range_low > cmd_i.item.range_high) ||
                  (CNT_W'(cmd_i.item.range_high) >= cmd_i.count)) begin
                res_d.status = ST_BAD_RANGE;
                state_d      = S_DONE;
              end else begin
                state_d = S_VISIT;
              end
            end
            default: begin
              state_d = S_CLEAR;
            end
          endcase
        end
      end
      S_D_RD: begin
        state_d = S_D_CHK;
      end
      S_D_CHK: begin
        if (s_q == e_q) begin
          if (item_q.mode == MODE_LOAD) begin
            mem_we = 1'b1;
            mem_wd = $unsigned(item_q.data);
          end else begin
            res_d.read_value = $signed(rdata_q);
          end
          state_d = S_DONE;
        end else if (rdata_q == '0) begin
          node_d = go_left ? lchild : rchild;
          s_d    = go_left ? s_q : mid + CNT_W'(1);
          e_d    = go_left ? mid : e_q;
          mem_ra = go_left ? lchild : rchild;
        end else begin
          p_d     = rdata_q;
          mem_ra  = lchild;
          state_d = S_D_PL;
        end
      end
      S_D_PL: begin
        mem_we  = 1'b1;
        mem_wa  = lchild;
        mem_wd  = rdata_q + p_q;
        mem_ra  = rchild;
        state_d = S_D_PR;
      end
      S_D_PR: begin
        mem_we  = 1'b1;
        mem_wa  = rchild;
        mem_wd  = rdata_q + p_q;
        state_d = S_D_PZ;
      end
      S_D_PZ: begin
        mem_we  = 1'b1;
        node_d  = go_left ? lchild : rchild;
        s_d     = go_left ? s_q : mid + CNT_W'(1);
        e_d     = go_left ? mid : e_q;
        mem_ra  = go_left ? lchild : rchild;
        state_d = S_D_CHK;
      end
      S_VISIT: begin
        if (add_q || disjoint) begin
          // tag write of a covered node (none for a disjoint one), then next pending sibling
          if (add_q) begin
            mem_we = 1'b1;
            mem_wd = rdata_q + $unsigned(item_q.data);
          end
          add_d = 1'b0;
          if (sp_q == '0) begin
            state_d = S_DONE;
          end else begin
            s_d    = top_ent.s;
            e_d    = top_ent.e;
            node_d = top_ent.node;
            sp_d   = sp_q - SPW'(1);
          end
        end else if (covered) begin
          add_d = 1'b1;
        end else begin
          push   = 1'b1;
          sp_d   = sp_q + SPW'(1);
          node_d = lchild;
          e_d    = mid;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      clr_q   <= '0;
      sp_q    <= '0;
      add_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      add_q   <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    node_q <= node_d;
    s_q    <= s_d;
    e_q    <= e_d;
    p_q    <= p_d;
    res_q  <= res_d;
  end

  assign res_o            = res_q;
  assign stat_o.ready     = (state_q == S_IDLE);
  assign stat_o.init      = (state_q == S_INIT);
  assign stat_o.res_valid = (state_q == S_DONE);

endmodule
